// ===== hdl/srfp_pkg.sv =====
// Types and constants shared by the sensor response frame parser.
`default_nettype none
package srfp_pkg;

   localparam int unsigned FRAME_BYTES = 9;
   localparam int unsigned POS_W       = 4;

   localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_CMD   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LOW   = POS_W'(3);
   localparam logic [POS_W-1:0] POS_FINAL = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BYTES);

   localparam logic [7:0] START_BYTE   = 8'hFF;
   localparam logic [7:0] READ_COMMAND = 8'h86;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_CMD = 2'd1,
      STATUS_BAD_SUM = 2'd2
   } status_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] concentration;
      status_type  frame_status;
   } result_type;

endpackage : srfp_pkg
`default_nettype wire

// ===== hdl/srfp_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
`default_nettype none
interface srfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface : srfp_req_if

interface srfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] concentration;
   logic [1:0]  frame_status;

   modport source (output valid, output concentration, output frame_status, input ready);
   modport sink   (input valid, input concentration, input frame_status, output ready);
endinterface : srfp_rsp_if
`default_nettype wire

// ===== hdl/srfp_in_stage.sv =====
// Input register holding one received byte.
`default_nettype none
module srfp_in_stage (
   input  wire logic clock,
   input  wire logic reset,
   srfp_req_if.sink  req_chan,
   input  wire logic consume,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign req_chan.ready = !valid_ff || consume;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule : srfp_in_stage
`default_nettype wire

// ===== hdl/srfp_frame_track.sv =====
// Frame position, running sum and field capture with command and checksum check.
`default_nettype none
module srfp_frame_track (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic byte_valid,
   input  wire logic [7:0] byte_data,
   input  wire logic room,
   output logic consume,
   output srfp_pkg::result_type result
);
   import srfp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       low_ff, low_in;
   logic             hunting;
   logic [7:0]       expect_sum;

   assign consume    = byte_valid && room;
   assign hunting    = (pos_ff == POS_HUNT) || (pos_ff >= POS_LIMIT);
   assign expect_sum = 8'(8'd0 - sum_ff);

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      cmd_in  = cmd_ff;
      high_in = high_ff;
      low_in  = low_ff;
      result  = '{valid: 1'b0, concentration: 16'd0, frame_status: STATUS_OK};
      if (consume) begin
         if (hunting) begin
            if (byte_data == START_BYTE) begin
               pos_in = POS_CMD;
               sum_in = 8'd0;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff < POS_FINAL) begin
            sum_in = 8'(sum_ff + byte_data);
            if (pos_ff == POS_CMD) begin
               cmd_in = byte_data;
            end
            if (pos_ff == POS_HIGH) begin
               high_in = byte_data;
            end
            if (pos_ff == POS_LOW) begin
               low_in = byte_data;
            end
            pos_in = POS_W'(pos_ff + POS_W'(1));
         end else begin
            result.valid = 1'b1;
            priority if (cmd_ff != READ_COMMAND) begin
               result.frame_status = STATUS_BAD_CMD;
            end else if (byte_data != expect_sum) begin
               result.frame_status = STATUS_BAD_SUM;
            end else begin
               result.frame_status  = STATUS_OK;
               result.concentration = {high_ff, low_ff};
            end
            pos_in = POS_HUNT;
            sum_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HUNT;
         sum_ff  <= 8'd0;
         cmd_ff  <= 8'd0;
         high_ff <= 8'd0;
         low_ff  <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         cmd_ff  <= cmd_in;
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_FINAL)
      else $error("frame position beyond final byte");

   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (pos_ff == POS_FINAL) && consume)
      else $error("result raised away from final byte");

   assert property (@(posedge clock) disable iff (reset)
      result.valid |=> (pos_ff == POS_HUNT) && (sum_ff == 8'd0))
      else $error("parser not back to hunting after a frame");

   assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.frame_status != STATUS_OK) |-> result.concentration == 16'd0)
      else $error("concentration not cleared on a bad frame");

endmodule : srfp_frame_track
`default_nettype wire

// ===== hdl/srfp_rsp_stage.sv =====
// Result register feeding the response channel.
`default_nettype none
module srfp_rsp_stage (
   input  wire logic clock,
   input  wire logic reset,
   input  wire srfp_pkg::result_type result,
   output logic room,
   srfp_rsp_if.source rsp_chan
);
   import srfp_pkg::*;

   logic        valid_ff, valid_in;
   logic [15:0] conc_ff;
   status_type  status_ff;

   assign room = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (room) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (room && result.valid) begin
         conc_ff   <= result.concentration;
         status_ff <= result.frame_status;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.concentration = conc_ff;
   assign rsp_chan.frame_status  = 2'(status_ff);

endmodule : srfp_rsp_stage
`default_nettype wire

// ===== hdl/sensor_response_frame_parser_top.sv =====
// Top level of the sensor response frame parser.
//
//  channel  dir  handshake    payload
//  req_chan in   valid/ready  rx_byte[7:0]
//  rsp_chan out  valid/ready  concentration[15:0], frame_status[1:0]
//
// One byte per cycle sustained while the response channel does not stall; a byte
// passes the input register, then the result register written on the checksum byte.
// A result item is produced on the ninth byte of each frame.
// Synchronous reset returns the parser to hunting for the start byte.
// A stalled result holds; bytes keep flowing until the result register blocks.
`default_nettype none
module sensor_response_frame_parser_top (
   input  wire logic   clock,
   input  wire logic   reset,
   srfp_req_if.sink    req_chan,
   srfp_rsp_if.source  rsp_chan
);
   import srfp_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       consume;
   logic       room;
   result_type result;

   srfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .consume    (consume),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   srfp_frame_track u_frame_track (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .room       (room),
      .consume    (consume),
      .result     (result)
   );

   srfp_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule : sensor_response_frame_parser_top
`default_nettype wire
